@@ hdl/bpq_pkg.sv @@
// Shared types and constants for the bucketed priority queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package bpq_pkg;
    localparam int CAPACITY  = 64;
    localparam int ID_LIMIT  = 65536;
    localparam int LEVELS    = 100;
    localparam int ID_W      = 16;
    localparam int LV_W      = 7;
    localparam int CIDX_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ARR_W     = $clog2(ID_LIMIT + 1);
    localparam logic [LV_W-1:0]  MAX_LV  = LV_W'(LEVELS - 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [ARR_W-1:0] ID_LIM  = ARR_W'(ID_LIMIT);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_RAISE  = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_ABSENT = 3'd2,
        ST_SAT    = 3'd3,
        ST_NOIDS  = 3'd4
    } t_status;

    typedef struct packed {
        t_cmd             cmd;
        logic [ID_W-1:0]  entry_id;
        logic [LV_W-1:0]  level_value;
    } t_req;

    typedef struct packed {
        logic count_nz;
        logic head_valid;
        logic state_ok;
    } t_back_stat;
endpackage

@@ hdl/bpq_front.sv @@
// Front part: takes requests and holds them in a two-entry queue.
// Depends on bpq_pkg.
`timescale 1ns / 1ps
module bpq_front import bpq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_req       i_req,
    output logic       o_q_valid,
    output t_req       o_q_req,
    input  logic       i_q_pop
);
    t_req       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push;

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_req    = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_req;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_q_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end
endmodule

@@ hdl/bpq_back.sv @@
// Back part: sorted cell chain, command sequencer and result register.
// Depends on bpq_pkg.
`timescale 1ns / 1ps
module bpq_back import bpq_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  t_req            i_q_req,
    output logic            o_q_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [ID_W-1:0] o_assigned_id,
    output logic [ID_W-1:0] o_top_id,
    output logic            o_is_empty,
    output t_status         o_status,
    output t_back_stat      o_stat
);
    typedef enum logic [1:0] {
        S_RUN   = 2'b01,
        S_REINS = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic [CAPACITY-1:0] r_v, n_v;
    logic [LV_W-1:0]     r_lv [CAPACITY];
    logic [LV_W-1:0]     n_lv [CAPACITY];
    logic [ID_W-1:0]     r_id [CAPACITY];
    logic [ID_W-1:0]     n_id [CAPACITY];
    logic [ARR_W-1:0]    r_arr, n_arr;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [LV_W-1:0]     r_rl, n_rl;
    logic [ID_W-1:0]     r_rid, n_rid;
    logic                r_rsat, n_rsat;

    logic            r_ov;
    logic [ID_W-1:0] r_oa, r_ot;
    logic            r_oe;
    t_status         r_os;

    logic [CAPACITY-1:0] beats, match;
    logic [CIDX_W-1:0]   m_idx;
    logic [LV_W-1:0]     m_lv;
    logic                found;
    logic [LV_W:0]       sum;
    logic                ins_en, rem_en;
    logic [LV_W-1:0]     k_lv;
    logic [ID_W-1:0]     k_id;
    logic                out_free, produce;
    logic [ID_W-1:0]     p_a, p_t;
    t_status             p_s;

    assign out_free = !r_ov || !i_out_stall;

    always_comb begin
        m_idx = '0;
        m_lv  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            beats[i] = r_v[i] && (r_lv[i] > k_lv || (r_lv[i] == k_lv && r_id[i] < k_id));
            match[i] = r_v[i] && (r_id[i] == i_q_req.entry_id);
            if (match[i]) begin
                m_idx = m_idx | CIDX_W'(i);
                m_lv  = m_lv | r_lv[i];
            end
        end
        found = |match;
        sum   = {1'b0, m_lv} + {1'b0, i_q_req.level_value};
    end

    always_comb begin
        n_state = r_state;
        n_arr   = r_arr;
        n_cnt   = r_cnt;
        n_rl    = r_rl;
        n_rid   = r_rid;
        n_rsat  = r_rsat;
        ins_en  = 1'b0;
        rem_en  = 1'b0;
        k_lv    = r_rl;
        k_id    = r_rid;
        o_q_pop = 1'b0;
        produce = 1'b0;
        p_a     = '0;
        p_t     = '0;
        p_s     = ST_OK;
        unique case (r_state)
            S_RUN: begin
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_req.cmd)
                        CMD_INSERT: begin
                            produce = 1'b1;
                            k_id    = r_arr[ID_W-1:0];
                            k_lv    = (i_q_req.level_value > MAX_LV) ? MAX_LV
                                                                     : i_q_req.level_value;
                            if (r_arr >= ID_LIM) begin
                                p_s = ST_NOIDS;
                            end else if (r_cnt >= CAP_CNT) begin
                                p_s = ST_FULL;
                            end else begin
                                ins_en = 1'b1;
                                p_a    = r_arr[ID_W-1:0];
                                p_s    = (i_q_req.level_value > MAX_LV) ? ST_SAT : ST_OK;
                                n_arr  = r_arr + 1'b1;
                                n_cnt  = r_cnt + 1'b1;
                            end
                        end
                        CMD_RAISE: begin
                            if (!found) begin
                                produce = 1'b1;
                                p_s     = ST_ABSENT;
                            end else begin
                                rem_en  = 1'b1;
                                n_rid   = i_q_req.entry_id;
                                n_rsat  = (sum > {1'b0, MAX_LV});
                                n_rl    = n_rsat ? MAX_LV : sum[LV_W-1:0];
                                n_state = S_REINS;
                            end
                        end
                        CMD_REMOVE: begin
                            produce = 1'b1;
                            if (!found) begin
                                p_s = ST_ABSENT;
                            end else begin
                                rem_en = 1'b1;
                                n_cnt  = r_cnt - 1'b1;
                            end
                        end
                        CMD_QUERY: begin
                            produce = 1'b1;
                            p_t     = (r_cnt != '0) ? r_id[0] : '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_REINS: begin
                ins_en  = 1'b1;
                produce = 1'b1;
                p_s     = r_rsat ? ST_SAT : ST_OK;
                n_state = S_RUN;
            end
            default: n_state = S_RUN;
        endcase
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_v[i]  = r_v[i];
            n_lv[i] = r_lv[i];
            n_id[i] = r_id[i];
            if (ins_en && !beats[i]) begin
                if (i == 0 || beats[(i == 0) ? 0 : i - 1]) begin
                    n_v[i]  = 1'b1;
                    n_lv[i] = k_lv;
                    n_id[i] = k_id;
                end else begin
                    n_v[i]  = r_v[(i == 0) ? 0 : i - 1];
                    n_lv[i] = r_lv[(i == 0) ? 0 : i - 1];
                    n_id[i] = r_id[(i == 0) ? 0 : i - 1];
                end
            end else if (rem_en && CIDX_W'(i) >= m_idx) begin
                if (i == CAPACITY - 1) begin
                    n_v[i] = 1'b0;
                end else begin
                    n_v[i]  = r_v[(i == CAPACITY - 1) ? i : i + 1];
                    n_lv[i] = r_lv[(i == CAPACITY - 1) ? i : i + 1];
                    n_id[i] = r_id[(i == CAPACITY - 1) ? i : i + 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lv <= n_lv;
        r_id <= n_id;
        r_rl <= n_rl;
        r_rid <= n_rid;
        r_rsat <= n_rsat;
        if (produce) begin
            r_oa <= p_a;
            r_ot <= p_t;
            r_oe <= (n_cnt == '0);
            r_os <= p_s;
        end
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_v     <= '0;
            r_arr   <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v     <= n_v;
            r_arr   <= n_arr;
            r_cnt   <= n_cnt;
            if (produce) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_ov;
    assign o_assigned_id = r_oa;
    assign o_top_id      = r_ot;
    assign o_is_empty    = r_oe;
    assign o_status      = r_os;

    // a raised entry is out of the chain until its reinsert
    assign o_stat.count_nz   = (r_cnt != '0);
    assign o_stat.head_valid = r_v[0] || (r_state == S_REINS);
    assign o_stat.state_ok   = $onehot(r_state);
endmodule

@@ hdl/bucketed_priority_queue.sv @@
// Top level of the bucketed priority queue: front queue plus back cell chain.
// Depends on bpq_pkg, bpq_front and bpq_back.
//
//   channel  direction  handshake              payload
//   request  in         i_in_valid/o_in_stall  i_cmd, i_entry_id, i_level_value
//   result   out        o_out_valid/i_out_stall o_assigned_id, o_top_id,
//                                               o_is_empty, o_status
//
// Insert, remove and query are done in state S_RUN; raise is a remove, then
// a sorted reinsert in S_REINS. Results go to one output register.
// A two-entry request queue lets requests arrive while the chain works.
// Synchronous active-low reset empties the store; no clearing pass is needed.
`timescale 1ns / 1ps
module bucketed_priority_queue import bpq_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [1:0]      i_cmd,
    input  logic [ID_W-1:0] i_entry_id,
    input  logic [LV_W-1:0] i_level_value,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [ID_W-1:0] o_assigned_id,
    output logic [ID_W-1:0] o_top_id,
    output logic            o_is_empty,
    output logic [2:0]      o_status
);
    t_req       in_req, q_req;
    logic       q_valid, q_pop;
    t_status    status;
    t_back_stat stat;

    assign in_req.cmd         = t_cmd'(i_cmd);
    assign in_req.entry_id    = i_entry_id;
    assign in_req.level_value = i_level_value;
    assign o_status           = status;

    bpq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_req      (in_req),
        .o_q_valid  (q_valid),
        .o_q_req    (q_req),
        .i_q_pop    (q_pop)
    );

    bpq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_req       (q_req),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_assigned_id (o_assigned_id),
        .o_top_id      (o_top_id),
        .o_is_empty    (o_is_empty),
        .o_status      (status),
        .o_stat        (stat)
    );

    a_head_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.count_nz == stat.head_valid)
        else $error("head cell valid disagrees with entry count");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.state_ok)
        else $error("sequencer state not one-hot");

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("request popped from empty queue");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && status == ST_FULL |-> !o_is_empty)
        else $error("full status with empty store");
endmodule
